>>> rtl/core/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg: shared types and constants of the line follower steering control
// Field widths, register indexes, reset values and the sequencer state type.
// ----------------------------------------------------------------------------
package lfsc_pkg;

    localparam int SENSOR_W = 5;
    localparam int SPEED_W  = 7;
    localparam int GAIN_W   = 6;
    localparam int DUTY_W   = 11;
    localparam int ERR_W    = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    localparam logic [DUTY_W-1:0] DUTY_MAX = 11'd2047;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_SPEED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_CAP    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_FLOOR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEER_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_REV    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MIRROR       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TURN  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LEVEL   = 3'd7;

    // reset values
    localparam logic [SPEED_W-1:0] RST_BASE_SPEED  = 7'd68;
    localparam logic [SPEED_W-1:0] RST_SPEED_CAP   = 7'd100;
    localparam logic [SPEED_W-1:0] RST_DRIVE_FLOOR = 7'd50;
    localparam logic [GAIN_W-1:0]  RST_STEER_GAIN  = 6'd32;
    localparam logic               RST_ALLOW_REV   = 1'b1;
    localparam logic               RST_MIRROR      = 1'b0;
    localparam logic [SPEED_W-1:0] RST_SEARCH_TURN = 7'd40;
    localparam logic               RST_LINE_LEVEL  = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_LEFT,
        ST_RIGHT,
        ST_DONE
    } lfsc_state_t;

endpackage

>>> rtl/core/line_follow_steering_control.sv
// ----------------------------------------------------------------------------
// line_follow_steering_control: five-sensor proportional steering
// Position error from five line sensors, differential wheel speeds, PWM duty.
// ----------------------------------------------------------------------------
// One sensor transaction is worked by a small sequencer; s_ready is high
// again only once the sequencer is back in ST_IDLE, and the time per
// transaction varies. The spread comes from the wait for the output slot and
// from the position-error divide, done by repeated subtraction of the active
// sensor count (one subtract per cycle, quotient 0..4).
// After that come the gain multiply, one state per wheel (ST_LEFT, ST_RIGHT)
// through the shared speed shaping and duty multiply unit, and ST_DONE to
// load the output register. The result sits in that register until the sink
// takes it; the next sensor transaction can be accepted meanwhile, and only
// the final load waits for the output slot. Configuration writes are taken
// in every cycle (cfg_ready is always high) and must only be issued while
// the block is idle. Duty is speed times PERIOD_TICKS/100, saturated at 2047.
module line_follow_steering_control
    import lfsc_pkg::*;
#(
    parameter int PERIOD_TICKS = 2000
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    // configuration write channel
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,

    // sensor input channel
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [SENSOR_W-1:0]       s_sensors,

    // wheel command output channel
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic                      m_left_reverse,
    output logic [DUTY_W-1:0]         m_left_duty,
    output logic                      m_right_reverse,
    output logic [DUTY_W-1:0]         m_right_duty,
    output logic signed [ERR_W-1:0]   m_track_error,
    output logic                      m_line_lost
);

    // duty scale: compare counts per percent
    localparam int DUTY_SCALE = PERIOD_TICKS / 100;
    localparam int SCALE_W    = $clog2(DUTY_SCALE + 1);
    localparam int PROD_W     = SPEED_W + SCALE_W;
    localparam int EXT_W      = (PROD_W > DUTY_W) ? PROD_W : DUTY_W;
    localparam logic [SCALE_W-1:0] SCALE_V = SCALE_W'(DUTY_SCALE);

    // speed arithmetic width: base (0..127) plus/minus gain*error (|.| <= 252)
    localparam int V_W    = 11;
    localparam int TURN_W = 11;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SPEED_W-1:0] base_speed_reg,  base_speed_next;
    logic [SPEED_W-1:0] speed_cap_reg,   speed_cap_next;
    logic [SPEED_W-1:0] drive_floor_reg, drive_floor_next;
    logic [GAIN_W-1:0]  steer_gain_reg,  steer_gain_next;
    logic               allow_rev_reg,   allow_rev_next;
    logic               mirror_reg,      mirror_next;
    logic [SPEED_W-1:0] search_turn_reg, search_turn_next;
    logic               line_level_reg,  line_level_next;

    assign cfg_ready = 1'b1;

    always_comb begin
        base_speed_next  = base_speed_reg;
        speed_cap_next   = speed_cap_reg;
        drive_floor_next = drive_floor_reg;
        steer_gain_next  = steer_gain_reg;
        allow_rev_next   = allow_rev_reg;
        mirror_next      = mirror_reg;
        search_turn_next = search_turn_reg;
        line_level_next  = line_level_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BASE_SPEED:  base_speed_next  = cfg_data[SPEED_W-1:0];
                CFG_SPEED_CAP:   speed_cap_next   = cfg_data[SPEED_W-1:0];
                CFG_DRIVE_FLOOR: drive_floor_next = cfg_data[SPEED_W-1:0];
                CFG_STEER_GAIN:  steer_gain_next  = cfg_data[GAIN_W-1:0];
                CFG_ALLOW_REV:   allow_rev_next   = cfg_data[0];
                CFG_MIRROR:      mirror_next      = cfg_data[0];
                CFG_SEARCH_TURN: search_turn_next = cfg_data[SPEED_W-1:0];
                CFG_LINE_LEVEL:  line_level_next  = cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_speed_reg  <= RST_BASE_SPEED;
            speed_cap_reg   <= RST_SPEED_CAP;
            drive_floor_reg <= RST_DRIVE_FLOOR;
            steer_gain_reg  <= RST_STEER_GAIN;
            allow_rev_reg   <= RST_ALLOW_REV;
            mirror_reg      <= RST_MIRROR;
            search_turn_reg <= RST_SEARCH_TURN;
            line_level_reg  <= RST_LINE_LEVEL;
        end else begin
            base_speed_reg  <= base_speed_next;
            speed_cap_reg   <= speed_cap_next;
            drive_floor_reg <= drive_floor_next;
            steer_gain_reg  <= steer_gain_next;
            allow_rev_reg   <= allow_rev_next;
            mirror_reg      <= mirror_next;
            search_turn_reg <= search_turn_next;
            line_level_reg  <= line_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Sensor decode at acceptance: active count and weighted sum.
    // Weights, right to left: +4 +2 0 -2 -4. The sum is kept as magnitude
    // and sign so the divide works on unsigned values and truncates to zero.
    // ------------------------------------------------------------------
    logic [SENSOR_W-1:0] hit;
    logic [2:0]          hit_cnt;
    logic [2:0]          pos_w, neg_w;
    logic [2:0]          sum_abs;
    logic                sum_neg;

    assign hit     = ~(s_sensors ^ {SENSOR_W{line_level_reg}});
    assign hit_cnt = 3'(hit[0]) + 3'(hit[1]) + 3'(hit[2]) + 3'(hit[3]) + 3'(hit[4]);
    assign pos_w   = (hit[0] ? 3'd4 : 3'd0) + (hit[1] ? 3'd2 : 3'd0);
    assign neg_w   = (hit[4] ? 3'd4 : 3'd0) + (hit[3] ? 3'd2 : 3'd0);
    assign sum_neg = (neg_w > pos_w);
    assign sum_abs = sum_neg ? (neg_w - pos_w) : (pos_w - neg_w);

    // ------------------------------------------------------------------
    // Sequencer registers
    // ------------------------------------------------------------------
    lfsc_state_t              state_reg, state_next;
    logic [2:0]               cnt_reg, cnt_next;
    logic [2:0]               rem_reg, rem_next;
    logic [2:0]               quo_reg, quo_next;
    logic                     neg_reg, neg_next;
    logic                     lost_reg, lost_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  rem_err_reg, rem_err_next;   // last error seen on line
    logic signed [TURN_W-1:0] turn_reg, turn_next;
    logic                     lrev_reg, lrev_next;
    logic [DUTY_W-1:0]        lduty_reg, lduty_next;
    logic                     rrev_reg, rrev_next;
    logic [DUTY_W-1:0]        rduty_reg, rduty_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_load;
    logic                     out_lrev_reg;
    logic [DUTY_W-1:0]        out_lduty_reg;
    logic                     out_rrev_reg;
    logic [DUTY_W-1:0]        out_rduty_reg;
    logic signed [ERR_W-1:0]  out_err_reg;
    logic                     out_lost_reg;

    // ------------------------------------------------------------------
    // Shared wheel unit: speed, shaping, direction and duty for one wheel.
    // ST_LEFT uses base + turn, ST_RIGHT base - turn.
    // ------------------------------------------------------------------
    logic                     wheel_right;
    logic signed [TURN_W-1:0] turn_sel;
    logic signed [V_W-1:0]    base_s, max_s, min_s, search_s;
    logic signed [V_W-1:0]    v_raw, v_cap, v_clamp, v_track, v_search, v_wheel;
    logic signed [V_W-1:0]    v_abs;
    logic [SPEED_W-1:0]       mag;
    logic                     w_rev;
    logic [PROD_W-1:0]        prod;
    logic [EXT_W-1:0]         prod_ext;
    logic [DUTY_W-1:0]        w_duty;

    assign wheel_right = (state_reg == ST_RIGHT);
    assign turn_sel    = wheel_right ? -turn_reg : turn_reg;
    assign base_s      = $signed({{(V_W-SPEED_W){1'b0}}, base_speed_reg});
    assign max_s       = $signed({{(V_W-SPEED_W){1'b0}}, speed_cap_reg});
    assign min_s       = $signed({{(V_W-SPEED_W){1'b0}}, drive_floor_reg});
    assign search_s    = -$signed({{(V_W-SPEED_W){1'b0}}, search_turn_reg});

    // tracking: cap, optional reverse clamp, raise to the drive floor
    assign v_raw   = base_s + V_W'(turn_sel);
    assign v_cap   = (v_raw > max_s) ? max_s : v_raw;
    assign v_clamp = (!allow_rev_reg && v_cap[V_W-1]) ? '0 : v_cap;
    assign v_track = (!v_clamp[V_W-1] && v_clamp != '0 && v_clamp < min_s) ? min_s : v_clamp;

    // search: inner wheel reverses toward the remembered side
    always_comb begin
        v_search = base_s;
        if (err_reg > 0) begin
            v_search = wheel_right ? search_s : base_s;
        end else if (err_reg < 0) begin
            v_search = wheel_right ? base_s : search_s;
        end
    end

    assign v_wheel  = lost_reg ? v_search : v_track;
    assign w_rev    = v_wheel[V_W-1];
    assign v_abs    = -v_wheel;
    // forward speed never exceeds 127; reverse magnitude saturates at the cap
    assign mag      = w_rev ? ((v_abs > max_s) ? speed_cap_reg : v_abs[SPEED_W-1:0])
                            : v_wheel[SPEED_W-1:0];
    assign prod     = PROD_W'(mag) * PROD_W'(SCALE_V);
    assign prod_ext = EXT_W'(prod);
    assign w_duty   = (prod_ext > EXT_W'(DUTY_MAX)) ? DUTY_MAX : prod_ext[DUTY_W-1:0];

    // ------------------------------------------------------------------
    // Sequencer next state
    // ------------------------------------------------------------------
    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        lost_next    = lost_reg;
        err_next     = err_reg;
        rem_err_next = rem_err_reg;
        turn_next    = turn_reg;
        lrev_next    = lrev_reg;
        lduty_next   = lduty_reg;
        rrev_next    = rrev_reg;
        rduty_next   = rduty_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cnt_next   = hit_cnt;
                    rem_next   = sum_abs;
                    neg_next   = sum_neg;
                    quo_next   = '0;
                    lost_next  = (hit_cnt == 3'd0);
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (lost_reg) begin
                    err_next   = rem_err_reg;
                    state_next = ST_MUL;
                end else if (rem_reg >= cnt_reg) begin
                    rem_next = rem_reg - cnt_reg;
                    quo_next = quo_reg + 3'd1;
                end else begin
                    // all five active gives sum 0, hence error 0
                    err_next     = (neg_reg ^ mirror_reg) ? -$signed({1'b0, quo_reg})
                                                          : $signed({1'b0, quo_reg});
                    rem_err_next = err_next;
                    state_next   = ST_MUL;
                end
            end
            ST_MUL: begin
                turn_next  = TURN_W'($signed({{(TURN_W-ERR_W){err_reg[ERR_W-1]}}, err_reg})
                           * $signed({{(TURN_W-GAIN_W){1'b0}}, steer_gain_reg}));
                state_next = ST_LEFT;
            end
            ST_LEFT: begin
                lrev_next  = w_rev;
                lduty_next = w_duty;
                state_next = ST_RIGHT;
            end
            ST_RIGHT: begin
                rrev_next  = w_rev;
                rduty_next = w_duty;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_valid_next = out_load || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            rem_err_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            rem_err_reg   <= rem_err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers, no reset
    always_ff @(posedge aclk) begin
        cnt_reg   <= cnt_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        neg_reg   <= neg_next;
        lost_reg  <= lost_next;
        err_reg   <= err_next;
        turn_reg  <= turn_next;
        lrev_reg  <= lrev_next;
        lduty_reg <= lduty_next;
        rrev_reg  <= rrev_next;
        rduty_reg <= rduty_next;
        if (out_load) begin
            out_lrev_reg  <= lrev_reg;
            out_lduty_reg <= lduty_reg;
            out_rrev_reg  <= rrev_reg;
            out_rduty_reg <= rduty_reg;
            out_err_reg   <= err_reg;
            out_lost_reg  <= lost_reg;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_left_reverse  = out_lrev_reg;
    assign m_left_duty     = out_lduty_reg;
    assign m_right_reverse = out_rrev_reg;
    assign m_right_duty    = out_rduty_reg;
    assign m_track_error   = out_err_reg;
    assign m_line_lost     = out_lost_reg;

endmodule

>>> rtl/core/lfsc_checker.sv
// ----------------------------------------------------------------------------
// lfsc_checker: port-level checks for line_follow_steering_control
// Output hold, wheel direction sanity, error range, busy after a transaction.
// ----------------------------------------------------------------------------
module lfsc_checker
    import lfsc_pkg::*;
(
    input logic                    aclk,
    input logic                    aresetn,
    input logic                    s_valid,
    input logic                    s_ready,
    input logic                    m_valid,
    input logic                    m_ready,
    input logic                    m_left_reverse,
    input logic [DUTY_W-1:0]       m_left_duty,
    input logic                    m_right_reverse,
    input logic [DUTY_W-1:0]       m_right_duty,
    input logic signed [ERR_W-1:0] m_track_error,
    input logic                    m_line_lost
);

    // stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_left_reverse) && $stable(m_left_duty)
            && $stable(m_right_reverse) && $stable(m_right_duty)
            && $stable(m_track_error) && $stable(m_line_lost))
        else $error("output changed while stalled");

    // base speed is never negative, so both wheels cannot run backward
    a_one_reverse: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_left_reverse && m_right_reverse))
        else $error("both wheels reversed");

    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_track_error >= -4) && (m_track_error <= 4))
        else $error("track error out of range");

    // the sequencer is busy after taking a sample
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready right after sensor transaction");

endmodule

bind line_follow_steering_control lfsc_checker u_lfsc_checker (.*);

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench of line_follow_steering_control
// Drives sensor samples and register writes with random idle gaps and output
// stalls. An in-bench predictor works out the wheel command of every accepted
// sample and the checker compares each result field by field.
// ----------------------------------------------------------------------------
module tb;
    import lfsc_pkg::*;

    localparam int PERIOD_TICKS = 2000;
    localparam int DUTY_STEP    = PERIOD_TICKS / 100;
    // extra quiet time after draining, to catch any late result
    localparam int DRAIN_CYCLES = 24;
    localparam int PHASE_ITEMS  = 100;
    localparam int PHASES       = 11;

    // one wheel command as the block should emit it
    typedef struct {
        logic                    left_rev;
        logic [DUTY_W-1:0]       left_duty;
        logic                    right_rev;
        logic [DUTY_W-1:0]       right_duty;
        logic signed [ERR_W-1:0] err;
        logic                    lost;
    } wheel_cmd_t;

    logic                    aclk;
    logic                    aresetn;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;
    logic                    s_valid;
    logic                    s_ready;
    logic [SENSOR_W-1:0]     s_sensors;
    logic                    m_valid;
    logic                    m_ready;
    logic                    m_left_reverse;
    logic [DUTY_W-1:0]       m_left_duty;
    logic                    m_right_reverse;
    logic [DUTY_W-1:0]       m_right_duty;
    logic signed [ERR_W-1:0] m_track_error;
    logic                    m_line_lost;

    // predictor copy of the registers and of the remembered error
    logic [SPEED_W-1:0]      base_spd;
    logic [SPEED_W-1:0]      max_spd;
    logic [SPEED_W-1:0]      min_drv;
    logic [GAIN_W-1:0]       gain;
    logic                    rev_ok;
    logic                    mirror;
    logic [SPEED_W-1:0]      search_spd;
    logic                    level;
    logic signed [ERR_W-1:0] last_err;

    wheel_cmd_t expected_cmds [$];
    int         errors;

    // idle switches: when low, the side runs back to back
    logic src_idle;
    logic sink_idle;

    line_follow_steering_control #(
        .PERIOD_TICKS(PERIOD_TICKS)
    ) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sensors      (s_sensors),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_left_reverse (m_left_reverse),
        .m_left_duty    (m_left_duty),
        .m_right_reverse(m_right_reverse),
        .m_right_duty   (m_right_duty),
        .m_track_error  (m_track_error),
        .m_line_lost    (m_line_lost)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // tracking mode only: cap, optional clamp of negatives, raise to the floor
    function automatic int shape_speed(input int v);
        if (v > int'(max_spd)) v = int'(max_spd);
        if (!rev_ok && v < 0) v = 0;
        // drive floor wins over the cap
        if (v > 0 && v < int'(min_drv)) v = int'(min_drv);
        return v;
    endfunction

    // signed speed -> direction bit and saturated compare value
    function automatic void wheel_duty(input int v, output logic rev,
                                       output logic [DUTY_W-1:0] duty);
        int mag;
        int d;
        rev = (v < 0);
        mag = v;
        if (v < 0) begin
            mag = -v;
            if (mag > int'(max_spd)) mag = int'(max_spd);
        end
        d = mag * DUTY_STEP;
        if (d > int'(DUTY_MAX)) d = int'(DUTY_MAX);
        duty = d[DUTY_W-1:0];
    endfunction

    // wheel command for one sample; updates the remembered error
    function automatic wheel_cmd_t predict_cmd(input logic [SENSOR_W-1:0] pins);
        wheel_cmd_t c;
        int hits;
        int sum;
        int err;
        int left;
        int right;
        int turn;
        hits = 0;
        sum  = 0;
        // weights run -4 at the leftmost pin (bit 4) to +4 at the rightmost
        for (int i = 0; i < SENSOR_W; i++) begin
            if (pins[i] == level) begin
                hits++;
                sum += 4 - 2 * i;
            end
        end
        if (hits == 0) begin
            // line lost: turn toward the side the line was last seen on
            err = int'(last_err);
            if (err > 0) begin
                left  = int'(base_spd);
                right = -int'(search_spd);
            end else if (err < 0) begin
                left  = -int'(search_spd);
                right = int'(base_spd);
            end else begin
                left  = int'(base_spd);
                right = int'(base_spd);
            end
            c.lost = 1'b1;
        end else begin
            // all five on the line counts as centered, mirror not applied
            if (hits == SENSOR_W) begin
                err = 0;
            end else begin
                err = sum / hits;   // truncates toward zero
                if (mirror) err = -err;
            end
            last_err = err[ERR_W-1:0];
            turn  = err * int'(gain);
            left  = shape_speed(int'(base_spd) + turn);
            right = shape_speed(int'(base_spd) - turn);
            c.lost = 1'b0;
        end
        wheel_duty(left, c.left_rev, c.left_duty);
        wheel_duty(right, c.right_rev, c.right_duty);
        c.err = err[ERR_W-1:0];
        return c;
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every output transaction against the oldest prediction
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        wheel_cmd_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_cmds.size() == 0) begin
                $error("wheel command with no sample pending");
                errors++;
            end else begin
                want = expected_cmds.pop_front();
                if (m_left_reverse !== want.left_rev) begin
                    $error("left_reverse: expected %0d, got %0d",
                           want.left_rev, m_left_reverse);
                    errors++;
                end
                if (m_left_duty !== want.left_duty) begin
                    $error("left_duty: expected %0d, got %0d",
                           want.left_duty, m_left_duty);
                    errors++;
                end
                if (m_right_reverse !== want.right_rev) begin
                    $error("right_reverse: expected %0d, got %0d",
                           want.right_rev, m_right_reverse);
                    errors++;
                end
                if (m_right_duty !== want.right_duty) begin
                    $error("right_duty: expected %0d, got %0d",
                           want.right_duty, m_right_duty);
                    errors++;
                end
                if (m_track_error !== want.err) begin
                    $error("track_error: expected %0d, got %0d",
                           want.err, m_track_error);
                    errors++;
                end
                if (m_line_lost !== want.lost) begin
                    $error("line_lost: expected %0d, got %0d",
                           want.lost, m_line_lost);
                    errors++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sink: with sink_idle high, a random stall ahead of every output transaction
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        m_ready = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            hold = sink_idle ? $urandom_range(0, 8) : 0;
            if (hold > 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------------
    // Shared drivers
    // ------------------------------------------------------------------------

    // one sensor transaction; valid stays up when the next one follows at once
    task automatic send_sample(input logic [SENSOR_W-1:0] pins);
        int gap;
        gap = src_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_sensors <= pins;
        do @(posedge aclk); while (!s_ready);
        expected_cmds.push_back(predict_cmd(pins));
    endtask

    // let every pending command drain, then give the block time to settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (expected_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_BASE_SPEED:  base_spd   = data;
            CFG_SPEED_CAP:   max_spd    = data;
            CFG_DRIVE_FLOOR: min_drv    = data;
            CFG_STEER_GAIN:  gain       = data[GAIN_W-1:0];
            CFG_ALLOW_REV:   rev_ok     = data[0];
            CFG_MIRROR:      mirror     = data[0];
            CFG_SEARCH_TURN: search_spd = data;
            CFG_LINE_LEVEL:  level      = data[0];
            default: ;
        endcase
    endtask

    // full register set, written only once the block has gone quiet
    task automatic set_config(input int bs, input int ms, input int md,
                              input int sg, input int ar, input int mi,
                              input int st, input int ll);
        wait_idle();
        write_reg(CFG_BASE_SPEED, bs[CFG_DATA_W-1:0]);
        write_reg(CFG_SPEED_CAP, ms[CFG_DATA_W-1:0]);
        write_reg(CFG_DRIVE_FLOOR, md[CFG_DATA_W-1:0]);
        write_reg(CFG_STEER_GAIN, sg[CFG_DATA_W-1:0]);
        write_reg(CFG_ALLOW_REV, ar[CFG_DATA_W-1:0]);
        write_reg(CFG_MIRROR, mi[CFG_DATA_W-1:0]);
        write_reg(CFG_SEARCH_TURN, st[CFG_DATA_W-1:0]);
        write_reg(CFG_LINE_LEVEL, ll[CFG_DATA_W-1:0]);
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // reset registers, line seen as a low pin: every error value but +2, search in
    // all three directions, all-five-on-line, truncation of both signs
    task automatic test_reset_tracking();
        logic [SENSOR_W-1:0] pats [14] = '{
            5'b11111, 5'b11110, 5'b11111, 5'b01111, 5'b11111, 5'b00000,
            5'b11011, 5'b11100, 5'b00111, 5'b10100, 5'b00101, 5'b11001,
            5'b01110, 5'b10111
        };
        foreach (pats[i]) send_sample(pats[i]);
    endtask

    // line seen as a high pin, mirrored error, no reverse while tracking;
    // search still reverses the inner wheel
    task automatic test_mirror_level();
        logic [SENSOR_W-1:0] pats [7] = '{
            5'b00001, 5'b00000, 5'b10000, 5'b00000, 5'b11111, 5'b00110,
            5'b01000
        };
        set_config(68, 100, 50, 32, 0, 1, 40, 1);
        foreach (pats[i]) send_sample(pats[i]);
    endtask

    // speeds beyond 102 percent push the duty past the 11-bit limit;
    // then a drive floor above the speed cap
    task automatic test_duty_saturation();
        set_config(127, 127, 127, 63, 1, 0, 127, 0);
        send_sample(5'b11011);
        send_sample(5'b11110);
        send_sample(5'b11111);
        send_sample(5'b01111);
        send_sample(5'b11111);
        set_config(60, 40, 90, 10, 0, 0, 40, 0);
        send_sample(5'b11101);
        send_sample(5'b10111);
    endtask

    // all-zero registers; a reverse command with zero magnitude
    task automatic test_zero_config();
        set_config(0, 0, 0, 0, 0, 0, 0, 0);
        send_sample(5'b11011);
        send_sample(5'b11110);
        send_sample(5'b11111);
        set_config(0, 0, 0, 0, 1, 0, 100, 0);
        send_sample(5'b11110);
        send_sample(5'b11111);
    endtask

    // register phases with random samples; lost-line and all-on-line patterns
    // are weighted up so search mode and the remembered error get exercised
    task automatic test_random();
        int pick;
        logic [SENSOR_W-1:0] pins;
        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph == 0)
                set_config(100, 100, 100, 63, 1, 1, 100, 1);
            else if (ph == 1)
                set_config(68, 100, 50, 32, 1, 0, 40, 0);
            else
                set_config($urandom_range(0, 100), $urandom_range(0, 100),
                           $urandom_range(0, 100), $urandom_range(0, 63),
                           $urandom_range(0, 1), $urandom_range(0, 1),
                           $urandom_range(0, 100), $urandom_range(0, 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // change the pacing every 25 samples, mostly with gaps
                if (n % 25 == 0) begin
                    src_idle  = ($urandom_range(0, 3) != 0);
                    sink_idle = ($urandom_range(0, 3) != 0);
                end
                pick = $urandom_range(0, 9);
                if (pick < 2)
                    pins = $urandom_range(0, 1) ? 5'b11111 : 5'b00000;
                else
                    pins = SENSOR_W'($urandom_range(0, 31));
                send_sample(pins);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_sensors = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BASE_SPEED;
        cfg_data  = '0;
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        errors    = 0;

        base_spd   = RST_BASE_SPEED;
        max_spd    = RST_SPEED_CAP;
        min_drv    = RST_DRIVE_FLOOR;
        gain       = RST_STEER_GAIN;
        rev_ok     = RST_ALLOW_REV;
        mirror     = RST_MIRROR;
        search_spd = RST_SEARCH_TURN;
        level      = RST_LINE_LEVEL;
        last_err   = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_tracking();
        test_mirror_level();
        test_duty_saturation();
        test_zero_config();
        test_random();

        // all pending commands out, then a quiet stretch for stray results
        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

endmodule
